/* sv/lpr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// Holds field widths, the cell command codes and the controller state type.
// No dependencies.
`default_nettype none

package lpr_pkg;

  localparam int IN_PAGE_W    = 16;
  localparam int EVICT_PAGE_W = 16;
  localparam int TOTAL_W      = 32;
  localparam int CFG_W        = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Update command broadcast to every frame cell.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_HIT,
    OP_LOAD,
    OP_EVICT
  } lpr_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lpr_state_t;

  // Default shapes of the cell chain and command; the top level overrides
  // them with widths derived from its parameters.
  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_rank;
    logic [15:0] victim_page;
  } lpr_chain_t;

  typedef struct packed {
    lpr_op_t    op;
    logic [3:0] bound;
    logic [4:0] count;
  } lpr_cmd_t;

endpackage

`default_nettype wire

/* sv/lpr_if.sv */
// Handshake channels of the LRU page replacement block: reference input,
// result output and frame-limit configuration. Depends on lpr_pkg.
`default_nettype none

interface lpr_in_if;
  logic                            valid;
  logic                            ready;
  logic [lpr_pkg::IN_PAGE_W-1:0]   page;
  logic                            final_access;
  modport source (output valid, page, final_access, input ready);
  modport sink   (input valid, page, final_access, output ready);
endinterface

interface lpr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             fault;
  logic                             evicted_valid;
  logic [lpr_pkg::EVICT_PAGE_W-1:0] evicted_page;
  logic [lpr_pkg::TOTAL_W-1:0]      fault_total;
  logic                             last_result;
  modport source (output valid, fault, evicted_valid, evicted_page, fault_total,
                  last_result, input ready);
  modport sink   (input valid, fault, evicted_valid, evicted_page, fault_total,
                  last_result, output ready);
endinterface

interface lpr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lpr_pkg::CFG_W-1:0]  frames_in_use;
  modport source (output valid, frames_in_use, input ready);
  modport sink   (input valid, frames_in_use, output ready);
endinterface

`default_nettype wire

/* sv/lpr_cell.sv */
// One frame cell of the LRU chain: page tag, valid bit and recency rank.
// Compares the broadcast page, passes hit and victim data to its neighbor.
// Depends on lpr_pkg.
`default_nettype none

module lpr_cell #(
  parameter int  PAGE_BITS = 16,
  parameter int  RANK_W    = 4,
  parameter int  CNT_W     = 5,
  parameter int  IDX       = 0,
  parameter type chain_t   = lpr_pkg::lpr_chain_t,
  parameter type cmd_t     = lpr_pkg::lpr_cmd_t
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [PAGE_BITS-1:0] look_page,
  input  wire cmd_t                 cmd,
  input  wire chain_t               chain_i,
  output chain_t                    chain_o
);

  logic                 valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 match;
  logic                 oldest;
  logic                 free_slot;
  logic                 younger;

  assign match     = valid_r && (page_r == look_page);
  assign oldest    = valid_r && (rank_r == RANK_W'(cmd.count - CNT_W'(1)));
  assign free_slot = (CNT_W'(IDX) == cmd.count);
  assign younger   = valid_r && (rank_r < cmd.bound);

  always_comb begin
    chain_o             = chain_i;
    chain_o.hit         = chain_i.hit | match;
    chain_o.hit_rank    = match ? rank_r : chain_i.hit_rank;
    chain_o.victim_page = oldest ? page_r : chain_i.victim_page;
  end

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    case (cmd.op)
      lpr_pkg::OP_HIT: begin
        if (match) begin
          rank_nxt = '0;
        end else if (younger) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
      end
      lpr_pkg::OP_LOAD: begin
        if (free_slot) begin
          valid_nxt = 1'b1;
          page_nxt  = look_page;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
      end
      lpr_pkg::OP_EVICT: begin
        if (oldest) begin
          page_nxt = look_page;
          rank_nxt = '0;
        end else if (younger) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
    page_r <= page_nxt;
  end

endmodule

`default_nettype wire

/* sv/lru_page_replacement_top.sv */
// LRU page replacement, fully associative, built as a chain of frame cells.
// Depends on lpr_pkg, lpr_if (channels) and lpr_cell.
//
// Usage:
//   in_if   : one page reference per item (page, final_access).
//   out_if  : one result per reference: fault, evicted_valid, evicted_page
//             (0 when nothing was evicted), saturating fault_total and
//             last_result, the echo of final_access.
//   cfg_if  : frame limit write, always ready; zero acts as one, values
//             above MAX_FRAMES act as MAX_FRAMES. Write only when idle.
// Timing:
//   An item is taken in the idle state and resolved in the exec state,
//   once the output register is free or being drained: every cell compares
//   its tag against the broadcast page, the hit rank and LRU victim ripple
//   down the cell chain, and the move-to-front update of the ranks lands at
//   the end of the resolve cycle. A new item is taken only after the last
//   one is resolved; result valid is registered and rises at the resolve edge.
//   The result sits in an output register; a new item is accepted while it
//   waits, but its resolve cycle holds until the output register frees up.
// Reset:
//   All frames empty, ranks zero, fault count zero, frame limit 16.
//   No clearing pass; frame tags are only read behind their valid bits.
`default_nettype none

module lru_page_replacement_top #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpr_in_if.sink      in_if,
  lpr_out_if.source   out_if,
  lpr_cfg_if.sink     cfg_if
);

  localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

  typedef struct packed {
    logic                 hit;
    logic [RANK_W-1:0]    hit_rank;
    logic [PAGE_BITS-1:0] victim_page;
  } chain_t;

  typedef struct packed {
    lpr_pkg::lpr_op_t  op;
    logic [RANK_W-1:0] bound;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  // Control state
  lpr_pkg::lpr_state_t         state_r, state_nxt;
  logic [lpr_pkg::CFG_W-1:0]   frames_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [lpr_pkg::TOTAL_W-1:0] faults_r, faults_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Held reference
  logic [PAGE_BITS-1:0]        page_r;
  logic                        last_r;

  // Result register
  logic                              out_fault_r;
  logic                              out_ev_r;
  logic [lpr_pkg::EVICT_PAGE_W-1:0]  out_ev_page_r;
  logic [lpr_pkg::TOTAL_W-1:0]       out_total_r;
  logic                              out_last_r;

  logic                              res_fault;
  logic                              res_ev;
  logic [lpr_pkg::EVICT_PAGE_W-1:0]  res_ev_page;

  logic             in_take;
  logic             exec_go;
  logic [CNT_W-1:0] limit;
  cmd_t             cmd;
  chain_t           chain [0:MAX_FRAMES];

  assign in_if.ready  = (state_r == lpr_pkg::ST_IDLE);
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // Resolve only when the output register is free or being drained.
  assign exec_go = (state_r == lpr_pkg::ST_EXEC) && (!out_valid_r || out_if.ready);

  // Effective frame limit: clamp to one .. MAX_FRAMES.
  always_comb begin
    if (frames_r == '0) begin
      limit = CNT_W'(1);
    end else if (int'(frames_r) > MAX_FRAMES) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = CNT_W'(frames_r);
    end
  end

  // Frame cell chain
  assign chain[0] = '0;

  for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_cell
    lpr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .RANK_W    (RANK_W),
      .CNT_W     (CNT_W),
      .IDX       (gi),
      .chain_t   (chain_t),
      .cmd_t     (cmd_t)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .look_page (page_r),
      .cmd       (cmd),
      .chain_i   (chain[gi]),
      .chain_o   (chain[gi+1])
    );
  end

  // Decide hit / load into free frame / evict LRU, and build the result.
  always_comb begin
    cmd.op      = lpr_pkg::OP_NONE;
    cmd.bound   = '0;
    cmd.count   = count_r;
    count_nxt   = count_r;
    faults_nxt  = faults_r;
    res_fault   = 1'b0;
    res_ev      = 1'b0;
    res_ev_page = '0;
    if (exec_go) begin
      if (chain[MAX_FRAMES].hit) begin
        cmd.op    = lpr_pkg::OP_HIT;
        cmd.bound = chain[MAX_FRAMES].hit_rank;
      end else begin
        res_fault = 1'b1;
        if (faults_r != '1) begin
          faults_nxt = faults_r + lpr_pkg::TOTAL_W'(1);
        end
        if (count_r < limit) begin
          cmd.op    = lpr_pkg::OP_LOAD;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          cmd.op      = lpr_pkg::OP_EVICT;
          cmd.bound   = RANK_W'(count_r - CNT_W'(1));
          res_ev      = 1'b1;
          res_ev_page = lpr_pkg::EVICT_PAGE_W'(chain[MAX_FRAMES].victim_page);
        end
      end
    end
  end

  // Controller
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = lpr_pkg::ST_EXEC;
        end
      end
      lpr_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt     = lpr_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpr_pkg::ST_IDLE;
      frames_r    <= lpr_pkg::CFG_RESET;
      count_r     <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        frames_r <= cfg_if.frames_in_use;
      end
    end
  end

  // Payload: hold the reference, load the result on resolve.
  always_ff @(posedge clk) begin
    if (in_take) begin
      page_r <= PAGE_BITS'(in_if.page);
      last_r <= in_if.final_access;
    end
    if (exec_go) begin
      out_fault_r   <= res_fault;
      out_ev_r      <= res_ev;
      out_ev_page_r <= res_ev_page;
      out_total_r   <= faults_nxt;
      out_last_r    <= last_r;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.fault         = out_fault_r;
  assign out_if.evicted_valid = out_ev_r;
  assign out_if.evicted_page  = out_ev_page_r;
  assign out_if.fault_total   = out_total_r;
  assign out_if.last_result   = out_last_r;

  // Checks
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lpr_pkg::ST_EXEC))
    else $error("result appeared without a resolve cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= MAX_FRAMES)
    else $error("occupancy count beyond frame count");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r |-> out_fault_r && (out_total_r != '0))
    else $error("eviction reported without a fault");

  a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == lpr_pkg::OP_LOAD |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("frame load did not advance occupancy");

endmodule

`default_nettype wire
